FILE: design/xalu_pkg.sv
`default_nettype none
package xalu_pkg;

    localparam int unsigned DW   = 32;
    localparam int unsigned FW   = 12;
    localparam int unsigned SWW  = 65;
    localparam int unsigned AMTW = 6;

    localparam logic [4:0] MODE_ADD  = 5'd0;
    localparam logic [4:0] MODE_ADC  = 5'd1;
    localparam logic [4:0] MODE_SUB  = 5'd2;
    localparam logic [4:0] MODE_SBB  = 5'd3;
    localparam logic [4:0] MODE_NEG  = 5'd4;
    localparam logic [4:0] MODE_CMP  = 5'd5;
    localparam logic [4:0] MODE_INC  = 5'd6;
    localparam logic [4:0] MODE_DEC  = 5'd7;
    localparam logic [4:0] MODE_AND  = 5'd8;
    localparam logic [4:0] MODE_OR   = 5'd9;
    localparam logic [4:0] MODE_XOR  = 5'd10;
    localparam logic [4:0] MODE_NOT  = 5'd11;
    localparam logic [4:0] MODE_TEST = 5'd12;
    localparam logic [4:0] MODE_SHL  = 5'd13;
    localparam logic [4:0] MODE_SHR  = 5'd14;
    localparam logic [4:0] MODE_SAR  = 5'd15;
    localparam logic [4:0] MODE_SHLD = 5'd16;
    localparam logic [4:0] MODE_SHRD = 5'd17;
    localparam logic [4:0] MODE_ROL  = 5'd18;
    localparam logic [4:0] MODE_ROR  = 5'd19;
    localparam logic [4:0] MODE_RCL  = 5'd20;
    localparam logic [4:0] MODE_RCR  = 5'd21;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;

    localparam int unsigned FL_CF = 0;
    localparam int unsigned FL_PF = 2;
    localparam int unsigned FL_AF = 4;
    localparam int unsigned FL_ZF = 6;
    localparam int unsigned FL_SF = 7;
    localparam int unsigned FL_OF = 11;

    typedef enum logic [3:0] {
        U_PASS, U_ADD, U_SUB, U_AND, U_OR, U_XOR, U_NOT,
        U_LSH, U_RSH, U_ROL, U_ROR, U_RCR
    } t_unit;

    typedef enum logic [2:0] {
        FC_NONE, FC_ARITH, FC_INCDEC, FC_LOGIC, FC_SHIFT, FC_ROT
    } t_fcls;

    typedef enum logic [2:0] {
        OK_ZERO, OK_ADD, OK_SUB, OK_SH1, OK_SHR1, OK_ROT
    } t_ofk;

    typedef struct packed {
        t_unit            op_unit;
        t_fcls            fcls;
        t_ofk             ofk;
        logic [1:0]       wc;
        logic [DW-1:0]    x;
        logic [DW-1:0]    y;
        logic             cin;
        logic [SWW-1:0]   sw;
        logic [AMTW-1:0]  amt;
        logic             x_s;
        logic             y_s;
        logic             a_s;
        logic             wb;
        logic [FW-1:0]    flags;
    } t_s1;

    typedef struct packed {
        logic [DW-1:0]    res;
        logic             cf;
        t_fcls            fcls;
        t_ofk             ofk;
        logic [1:0]       wc;
        logic             x_s;
        logic             y_s;
        logic             a_s;
        logic             wb;
        logic [FW-1:0]    flags;
    } t_s2;

    function automatic logic [DW-1:0] width_mask(input logic [1:0] wc);
        logic [DW-1:0] m;
        case (wc)
            WC_8:    m = 32'h0000_00FF;
            WC_16:   m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic sign_of(input logic [DW-1:0] v, input logic [1:0] wc);
        logic s;
        case (wc)
            WC_8:    s = v[7];
            WC_16:   s = v[15];
            default: s = v[31];
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: design/x86_integer_alu_flags_unit.sv
// x86 integer ALU with flags. One operation enters per clock while o_stall
// is low and passes through operand decode and masking, then the adder or
// the 65-bit shifter, then flag generation into the output register. Each
// stage holds its beat only while the stage after it is full and cannot
// advance, so o_stall rises only when all three stages are full and the
// output is stalled; empty stages keep taking beats while a result waits.
`default_nettype none
module x86_integer_alu_flags_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [4:0]    i_mode,
    input  wire logic [1:0]    i_width_code,
    input  wire logic [31:0]   i_operand_a,
    input  wire logic [31:0]   i_operand_b,
    input  wire logic [7:0]    i_shift_count,
    input  wire logic [11:0]   i_flags_in,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [31:0]        o_result,
    output logic [11:0]        o_flags_out,
    output logic               o_write_back
);
    import xalu_pkg::*;

    t_s1  s1;
    t_s2  s2;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;

    // advance a stage when the next one is empty or advancing
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    xalu_decode u_decode (
        .i_clk         (i_clk),
        .i_en          (en1),
        .i_mode        (i_mode),
        .i_width_code  (i_width_code),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_shift_count (i_shift_count),
        .i_flags_in    (i_flags_in),
        .o_s1          (s1)
    );

    xalu_exec u_exec (
        .i_clk (i_clk),
        .i_en  (en2),
        .i_s1  (s1),
        .o_s2  (s2)
    );

    xalu_flags u_flags (
        .i_clk        (i_clk),
        .i_en         (en3),
        .i_s2         (s2),
        .o_result     (o_result),
        .o_flags_out  (o_flags_out),
        .o_write_back (o_write_back)
    );

endmodule
`default_nettype wire

FILE: design/xalu_decode.sv
`default_nettype none
module xalu_decode (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [4:0]    i_mode,
    input  wire logic [1:0]    i_width_code,
    input  wire logic [31:0]   i_operand_a,
    input  wire logic [31:0]   i_operand_b,
    input  wire logic [7:0]    i_shift_count,
    input  wire logic [11:0]   i_flags_in,
    output xalu_pkg::t_s1      o_s1
);
    import xalu_pkg::*;

    t_s1            r_s1;
    t_s1            n_s1;
    logic [DW-1:0]  m;
    logic [DW-1:0]  a_m;
    logic [DW-1:0]  b_m;
    logic [4:0]     n;
    logic           sgn;
    logic           zero_cnt;
    logic [4:0]     k;
    logic [5:0]     splus1;
    logic [5:0]     j_rcl;

    function automatic logic [SWW-1:0] lform(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                             input logic [1:0] wc);
        logic [SWW-1:0] v;
        case (wc)
            WC_8:    v = {1'b0, a[7:0], b[7:0], 48'd0};
            WC_16:   v = {1'b0, a[15:0], b[15:0], 32'd0};
            default: v = {1'b0, a, b};
        endcase
        return v;
    endfunction

    function automatic logic [SWW-1:0] rform(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                             input logic [1:0] wc);
        logic [SWW-1:0] v;
        case (wc)
            WC_8:    v = {49'd0, b[7:0], a[7:0]};
            WC_16:   v = {33'd0, b[15:0], a[15:0]};
            default: v = {1'b0, b, a};
        endcase
        return v;
    endfunction

    function automatic logic [SWW-1:0] rep32(input logic [DW-1:0] a, input logic [1:0] wc);
        logic [SWW-1:0] v;
        case (wc)
            WC_8:    v = {33'd0, {4{a[7:0]}}};
            WC_16:   v = {33'd0, {2{a[15:0]}}};
            default: v = {33'd0, a};
        endcase
        return v;
    endfunction

    function automatic logic [SWW-1:0] rcform(input logic [DW-1:0] a, input logic c,
                                              input logic [1:0] wc);
        logic [SWW-1:0] v;
        case (wc)
            WC_8:    v = {47'd0, c, a[7:0], c, a[7:0]};
            WC_16:   v = {31'd0, c, a[15:0], c, a[15:0]};
            default: v = {a, c, a};
        endcase
        return v;
    endfunction

    always_comb begin
        m        = width_mask(i_width_code);
        a_m      = i_operand_a & m;
        b_m      = i_operand_b & m;
        n        = i_shift_count[4:0];
        sgn      = sign_of(a_m, i_width_code);
        zero_cnt = (i_mode >= MODE_SHL) && (i_mode <= MODE_RCR) && (n == 5'd0);

        case (i_width_code)
            WC_8: begin
                splus1 = 6'd9;
                if (n >= 5'd27) begin
                    k = n - 5'd27;
                end else if (n >= 5'd18) begin
                    k = n - 5'd18;
                end else if (n >= 5'd9) begin
                    k = n - 5'd9;
                end else begin
                    k = n;
                end
            end
            WC_16: begin
                splus1 = 6'd17;
                k      = (n >= 5'd17) ? n - 5'd17 : n;
            end
            default: begin
                splus1 = 6'd33;
                k      = n;
            end
        endcase
        j_rcl = (k == 5'd0) ? 6'd0 : splus1 - {1'b0, k};

        n_s1         = '0;
        n_s1.op_unit = U_PASS;
        n_s1.fcls    = FC_NONE;
        n_s1.ofk     = OK_ZERO;
        n_s1.wc      = i_width_code;
        n_s1.x       = a_m;
        n_s1.y       = b_m;
        n_s1.cin     = 1'b0;
        n_s1.amt     = {1'b0, n};
        n_s1.wb      = 1'b1;
        n_s1.flags   = i_flags_in;

        case (i_mode)
            MODE_ADD: begin
                n_s1.op_unit = U_ADD;
                n_s1.fcls    = FC_ARITH;
                n_s1.ofk     = OK_ADD;
            end
            MODE_ADC: begin
                n_s1.op_unit = U_ADD;
                n_s1.fcls    = FC_ARITH;
                n_s1.ofk     = OK_ADD;
                n_s1.cin     = i_flags_in[FL_CF];
            end
            MODE_SUB: begin
                n_s1.op_unit = U_SUB;
                n_s1.fcls    = FC_ARITH;
                n_s1.ofk     = OK_SUB;
            end
            MODE_SBB: begin
                n_s1.op_unit = U_SUB;
                n_s1.fcls    = FC_ARITH;
                n_s1.ofk     = OK_SUB;
                n_s1.cin     = i_flags_in[FL_CF];
            end
            MODE_NEG: begin
                n_s1.op_unit = U_SUB;
                n_s1.fcls    = FC_ARITH;
                n_s1.ofk     = OK_SUB;
                n_s1.x       = '0;
                n_s1.y       = a_m;
            end
            MODE_CMP: begin
                n_s1.op_unit = U_SUB;
                n_s1.fcls    = FC_ARITH;
                n_s1.ofk     = OK_SUB;
                n_s1.wb      = 1'b0;
            end
            MODE_INC: begin
                n_s1.op_unit = U_ADD;
                n_s1.fcls    = FC_INCDEC;
                n_s1.ofk     = OK_ADD;
                n_s1.y       = 32'd1;
            end
            MODE_DEC: begin
                n_s1.op_unit = U_SUB;
                n_s1.fcls    = FC_INCDEC;
                n_s1.ofk     = OK_SUB;
                n_s1.y       = 32'd1;
            end
            MODE_AND: begin
                n_s1.op_unit = U_AND;
                n_s1.fcls    = FC_LOGIC;
            end
            MODE_OR: begin
                n_s1.op_unit = U_OR;
                n_s1.fcls    = FC_LOGIC;
            end
            MODE_XOR: begin
                n_s1.op_unit = U_XOR;
                n_s1.fcls    = FC_LOGIC;
            end
            MODE_NOT: begin
                n_s1.op_unit = U_NOT;
            end
            MODE_TEST: begin
                n_s1.op_unit = U_AND;
                n_s1.fcls    = FC_LOGIC;
                n_s1.wb      = 1'b0;
            end
            MODE_SHL: begin
                n_s1.op_unit = U_LSH;
                n_s1.fcls    = FC_SHIFT;
                n_s1.ofk     = (n == 5'd1) ? OK_SH1 : OK_ZERO;
                n_s1.sw      = lform(a_m, '0, i_width_code);
            end
            MODE_SHLD: begin
                n_s1.op_unit = U_LSH;
                n_s1.fcls    = FC_SHIFT;
                n_s1.ofk     = (n == 5'd1) ? OK_SH1 : OK_ZERO;
                n_s1.sw      = lform(a_m, b_m, i_width_code);
            end
            MODE_SHR: begin
                n_s1.op_unit = U_RSH;
                n_s1.fcls    = FC_SHIFT;
                n_s1.ofk     = (n == 5'd1) ? OK_SHR1 : OK_ZERO;
                n_s1.sw      = {33'd0, a_m};
            end
            MODE_SAR: begin
                n_s1.op_unit = U_RSH;
                n_s1.fcls    = FC_SHIFT;
                n_s1.sw      = {1'b0, {32{sgn}}, a_m | (sgn ? ~m : 32'd0)};
            end
            MODE_SHRD: begin
                n_s1.op_unit = U_RSH;
                n_s1.fcls    = FC_SHIFT;
                n_s1.ofk     = (n == 5'd1) ? OK_SH1 : OK_ZERO;
                n_s1.sw      = rform(a_m, b_m, i_width_code);
            end
            MODE_ROL: begin
                n_s1.op_unit = U_ROL;
                n_s1.fcls    = FC_ROT;
                n_s1.ofk     = OK_ROT;
                n_s1.sw      = rep32(a_m, i_width_code);
            end
            MODE_ROR: begin
                n_s1.op_unit = U_ROR;
                n_s1.fcls    = FC_ROT;
                n_s1.ofk     = OK_ROT;
                n_s1.sw      = rep32(a_m, i_width_code);
            end
            MODE_RCL: begin
                n_s1.op_unit = U_RCR;
                n_s1.fcls    = FC_ROT;
                n_s1.ofk     = OK_ROT;
                n_s1.sw      = rcform(a_m, i_flags_in[FL_CF], i_width_code);
                n_s1.amt     = j_rcl;
            end
            MODE_RCR: begin
                n_s1.op_unit = U_RCR;
                n_s1.fcls    = FC_ROT;
                n_s1.ofk     = OK_ROT;
                n_s1.sw      = rcform(a_m, i_flags_in[FL_CF], i_width_code);
                n_s1.amt     = {1'b0, k};
            end
            default: begin
                n_s1.wb = 1'b0;
            end
        endcase

        // zero count: pass operand, keep flags, no write
        if (zero_cnt) begin
            n_s1.op_unit = U_PASS;
            n_s1.fcls    = FC_NONE;
            n_s1.wb      = 1'b0;
        end

        n_s1.x_s = sign_of(n_s1.x, i_width_code);
        n_s1.y_s = sign_of(n_s1.y, i_width_code);
        n_s1.a_s = sgn;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule
`default_nettype wire

FILE: design/xalu_exec.sv
`default_nettype none
module xalu_exec (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  xalu_pkg::t_s1      i_s1,
    output xalu_pkg::t_s2      o_s2
);
    import xalu_pkg::*;

    t_s2             r_s2;
    t_s2             n_s2;
    logic [DW-1:0]   m;
    logic [DW:0]     sum;
    logic [DW+1:0]   diff;
    logic [SWW-1:0]  lsh;
    logic [SWW-1:0]  rsh;
    logic [SWW-1:0]  rcw;
    logic [2*DW-1:0] rot2;
    logic [2*DW-1:0] rol_w;
    logic [2*DW-1:0] ror_w;
    logic [DW-1:0]   res;
    logic            cf;

    always_comb begin
        m     = width_mask(i_s1.wc);
        sum   = {1'b0, i_s1.x} + {1'b0, i_s1.y} + {32'd0, i_s1.cin};
        diff  = {2'b00, i_s1.x} - {2'b00, i_s1.y} - {33'd0, i_s1.cin};
        lsh   = {1'b0, i_s1.sw[63:0]} << i_s1.amt;
        rsh   = {i_s1.sw[63:0], 1'b0} >> i_s1.amt;
        rcw   = i_s1.sw >> i_s1.amt;
        rot2  = {i_s1.sw[31:0], i_s1.sw[31:0]};
        rol_w = rot2 << i_s1.amt[4:0];
        ror_w = rot2 >> i_s1.amt[4:0];

        res = i_s1.x;
        cf  = 1'b0;
        case (i_s1.op_unit)
            U_ADD: begin
                res = sum[31:0] & m;
                case (i_s1.wc)
                    WC_8:    cf = sum[8];
                    WC_16:   cf = sum[16];
                    default: cf = sum[32];
                endcase
            end
            U_SUB: begin
                res = diff[31:0] & m;
                cf  = diff[33];
            end
            U_AND: res = i_s1.x & i_s1.y;
            U_OR:  res = i_s1.x | i_s1.y;
            U_XOR: res = i_s1.x ^ i_s1.y;
            U_NOT: res = ~i_s1.x & m;
            U_LSH: begin
                case (i_s1.wc)
                    WC_8:    res = {24'd0, lsh[63:56]};
                    WC_16:   res = {16'd0, lsh[63:48]};
                    default: res = lsh[63:32];
                endcase
                cf = lsh[64];
            end
            U_RSH: begin
                res = rsh[32:1] & m;
                cf  = rsh[0];
            end
            U_ROL: begin
                res = rol_w[63:32] & m;
                cf  = res[0];
            end
            U_ROR: begin
                res = ror_w[31:0] & m;
                cf  = sign_of(res, i_s1.wc);
            end
            U_RCR: begin
                res = rcw[31:0] & m;
                case (i_s1.wc)
                    WC_8:    cf = rcw[8];
                    WC_16:   cf = rcw[16];
                    default: cf = rcw[32];
                endcase
            end
            default: res = i_s1.x;
        endcase

        n_s2.res   = res;
        n_s2.cf    = cf;
        n_s2.fcls  = i_s1.fcls;
        n_s2.ofk   = i_s1.ofk;
        n_s2.wc    = i_s1.wc;
        n_s2.x_s   = i_s1.x_s;
        n_s2.y_s   = i_s1.y_s;
        n_s2.a_s   = i_s1.a_s;
        n_s2.wb    = i_s1.wb;
        n_s2.flags = i_s1.flags;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule
`default_nettype wire

FILE: design/xalu_flags.sv
`default_nettype none
module xalu_flags (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  xalu_pkg::t_s2      i_s2,
    output logic [31:0]        o_result,
    output logic [11:0]        o_flags_out,
    output logic               o_write_back
);
    import xalu_pkg::*;

    logic [DW-1:0] r_result;
    logic [FW-1:0] r_flags;
    logic          r_wb;
    logic [FW-1:0] n_flags;
    logic          res_s;
    logic          zf;
    logic          pf;
    logic          of;

    always_comb begin
        res_s = sign_of(i_s2.res, i_s2.wc);
        zf    = (i_s2.res == '0);
        pf    = ~^i_s2.res[7:0];
        case (i_s2.ofk)
            OK_ADD:  of = (i_s2.x_s ^ res_s) & (i_s2.y_s ^ res_s);
            OK_SUB:  of = (i_s2.x_s ^ i_s2.y_s) & (i_s2.x_s ^ res_s);
            OK_SH1:  of = i_s2.a_s ^ res_s;
            OK_SHR1: of = i_s2.a_s;
            OK_ROT:  of = i_s2.a_s ^ res_s;
            default: of = 1'b0;
        endcase

        n_flags = i_s2.flags;
        case (i_s2.fcls)
            FC_ARITH: begin
                n_flags[FL_AF] = 1'b0;
                n_flags[FL_CF] = i_s2.cf;
                n_flags[FL_OF] = of;
                n_flags[FL_ZF] = zf;
                n_flags[FL_SF] = res_s;
                n_flags[FL_PF] = pf;
            end
            FC_INCDEC: begin
                n_flags[FL_AF] = 1'b0;
                n_flags[FL_OF] = of;
                n_flags[FL_ZF] = zf;
                n_flags[FL_SF] = res_s;
                n_flags[FL_PF] = pf;
            end
            FC_LOGIC: begin
                n_flags[FL_CF] = 1'b0;
                n_flags[FL_OF] = 1'b0;
                n_flags[FL_ZF] = zf;
                n_flags[FL_SF] = res_s;
                n_flags[FL_PF] = pf;
            end
            FC_SHIFT: begin
                n_flags[FL_CF] = i_s2.cf;
                n_flags[FL_OF] = of;
                n_flags[FL_ZF] = zf;
                n_flags[FL_SF] = res_s;
                n_flags[FL_PF] = pf;
            end
            FC_ROT: begin
                n_flags[FL_CF] = i_s2.cf;
                n_flags[FL_OF] = of;
            end
            default: n_flags = i_s2.flags;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= i_s2.res;
            r_flags  <= n_flags;
            r_wb     <= i_s2.wb;
        end
    end

    assign o_result     = r_result;
    assign o_flags_out  = r_flags;
    assign o_write_back = r_wb;

endmodule
`default_nettype wire

FILE: design/xalu_assert.sv
`default_nettype none
module xalu_assert (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          o_stall,
    input  wire logic          o_valid,
    input  wire logic          i_stall,
    input  wire logic [31:0]   o_result,
    input  wire logic [11:0]   o_flags_out,
    input  wire logic          o_write_back
);

    // back-pressure only when the output holds a beat and is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while pipeline has room");

    // a beat accepted while the output runs free reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted beat did not reach the output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)
            && $stable(o_flags_out) && $stable(o_write_back)))
        else $error("stalled output beat changed");

endmodule

bind x86_integer_alu_flags_unit xalu_assert u_xalu_assert (.*);
`default_nettype wire

FILE: test/x86_integer_alu_flags_unit_tb.sv
`timescale 1ns / 1ps
module x86_integer_alu_flags_unit_tb;
    import xalu_pkg::*;

    localparam logic [1:0] WC_32    = 2'd2;
    localparam logic [1:0] WC_RSVD  = 2'd3;
    localparam logic [4:0] MODE_LAST = 5'd31;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;

    typedef struct packed {
        logic [4:0]  mode;
        logic [1:0]  wc;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [7:0]  count;
        logic [11:0] flags;
    } t_alu_op;

    typedef struct packed {
        logic [31:0] result;
        logic [11:0] flags;
        logic        wb;
    } t_alu_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [4:0]  i_mode = '0;
    logic [1:0]  i_width_code = '0;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    logic [7:0]  i_shift_count = '0;
    logic [11:0] i_flags_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_result;
    logic [11:0] o_flags_out;
    logic        o_write_back;

    t_alu_res    pending_results[$];
    int unsigned errors = 0;
    int unsigned ops_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_burst = 0;
    bit          src_idle_en = 1'b0;
    bit          sink_idle_en = 1'b0;
    bit          long_hold = 1'b0;
    event        hold_trig;

    x86_integer_alu_flags_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_width_code  (i_width_code),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_shift_count (i_shift_count),
        .i_flags_in    (i_flags_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (o_result),
        .o_flags_out   (o_flags_out),
        .o_write_back  (o_write_back)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] set_szp(input logic [63:0] f, input logic [63:0] r,
                                            input logic [63:0] h);
        f[FL_ZF] = (r == 64'd0);
        f[FL_SF] = |(r & h);
        f[FL_PF] = ~^r[7:0];
        return f;
    endfunction

    function automatic logic [63:0] logic_flags(input logic [63:0] f, input logic [63:0] r,
                                                input logic [63:0] h);
        f[FL_CF] = 1'b0;
        f[FL_OF] = 1'b0;
        return set_szp(f, r, h);
    endfunction

    function automatic t_alu_res alu_predict(input t_alu_op op);
        int unsigned s;
        int unsigned n;
        int unsigned k;
        logic [63:0] m, h, a, b, f, cf, r, x, y, c, full, ext, cat, m1, v, w;
        logic        wb;
        t_alu_res    o;
        case (op.wc)
            WC_8:    s = 8;
            WC_16:   s = 16;
            default: s = 32;
        endcase
        m  = (64'd1 << s) - 64'd1;
        h  = 64'd1 << (s - 1);
        a  = {32'd0, op.opa} & m;
        b  = {32'd0, op.opb} & m;
        n  = op.count[4:0];
        f  = {52'd0, op.flags};
        cf = {63'd0, op.flags[FL_CF]};
        r  = a;
        wb = 1'b1;
        if (op.mode >= MODE_SHL && op.mode <= MODE_RCR && n == 0) begin
            wb = 1'b0;
        end else begin
            case (op.mode)
                MODE_ADD, MODE_ADC, MODE_INC: begin
                    y = (op.mode == MODE_INC) ? 64'd1 : b;
                    c = (op.mode == MODE_ADC) ? cf : 64'd0;
                    full = a + y + c;
                    r = full & m;
                    f = set_szp(f, r, h);
                    f[FL_AF] = 1'b0;
                    f[FL_CF] = (op.mode == MODE_INC) ? op.flags[FL_CF] : full[s];
                    f[FL_OF] = |((a ^ r) & (y ^ r) & h);
                end
                MODE_SUB, MODE_SBB, MODE_NEG, MODE_CMP, MODE_DEC: begin
                    x = (op.mode == MODE_NEG) ? 64'd0 : a;
                    y = (op.mode == MODE_NEG) ? a : (op.mode == MODE_DEC) ? 64'd1 : b;
                    c = (op.mode == MODE_SBB) ? cf : 64'd0;
                    r = (x - y - c) & m;
                    f = set_szp(f, r, h);
                    f[FL_AF] = 1'b0;
                    f[FL_CF] = (op.mode == MODE_DEC) ? op.flags[FL_CF] : (x < y + c);
                    f[FL_OF] = |((x ^ y) & (x ^ r) & h);
                    wb = (op.mode != MODE_CMP);
                end
                MODE_AND, MODE_TEST: begin
                    r = a & b;
                    f = logic_flags(f, r, h);
                    wb = (op.mode != MODE_TEST);
                end
                MODE_OR: begin
                    r = a | b;
                    f = logic_flags(f, r, h);
                end
                MODE_XOR: begin
                    r = a ^ b;
                    f = logic_flags(f, r, h);
                end
                MODE_NOT: begin
                    r = ~a & m;
                end
                MODE_SHL: begin
                    r = (a << n) & m;
                    f = logic_flags(f, r, h);
                    f[FL_CF] = |((a << (n - 1)) & h);
                    if (n == 1) f[FL_OF] = |((a ^ r) & h);
                end
                MODE_SHR: begin
                    r = a >> n;
                    f = logic_flags(f, r, h);
                    f[FL_CF] = a[n - 1];
                    if (n == 1) f[FL_OF] = |(a & h);
                end
                MODE_SAR: begin
                    ext = (|(a & h)) ? (a | ~m) : a;
                    r = (ext >> n) & m;
                    f = logic_flags(f, r, h);
                    f[FL_CF] = ext[n - 1];
                end
                MODE_SHLD: begin
                    cat = (a << s) | b;
                    r = ((cat << n) >> s) & m;
                    f = logic_flags(f, r, h);
                    w = cat << (n - 1);
                    f[FL_CF] = w[2 * s - 1];
                    if (n == 1) f[FL_OF] = |((a ^ r) & h);
                end
                MODE_SHRD: begin
                    cat = (b << s) | a;
                    r = (cat >> n) & m;
                    f = logic_flags(f, r, h);
                    f[FL_CF] = cat[n - 1];
                    if (n == 1) f[FL_OF] = |((a ^ r) & h);
                end
                MODE_ROL, MODE_ROR: begin
                    k = n & (s - 1);
                    if (op.mode == MODE_ROL) begin
                        r = ((a << k) | (a >> (s - k))) & m;
                        f[FL_CF] = r[0];
                    end else begin
                        r = ((a >> k) | (a << (s - k))) & m;
                        f[FL_CF] = |(r & h);
                    end
                    f[FL_OF] = |((a ^ r) & h);
                end
                MODE_RCL, MODE_RCR: begin
                    k  = n % (s + 1);
                    m1 = (64'd1 << (s + 1)) - 64'd1;
                    v  = (cf << s) | a;
                    if (op.mode == MODE_RCL) begin
                        w = ((v << k) | (v >> (s + 1 - k))) & m1;
                    end else begin
                        w = ((v >> k) | (v << (s + 1 - k))) & m1;
                    end
                    r = w & m;
                    f[FL_CF] = w[s];
                    f[FL_OF] = |((a ^ r) & h);
                end
                default: begin
                    wb = 1'b0;
                end
            endcase
        end
        o.result = r[31:0];
        o.flags  = f[11:0];
        o.wb     = wb;
        return o;
    endfunction

    function automatic t_alu_op op_of(input logic [4:0] mode, input logic [1:0] wc,
                                      input logic [31:0] opa, input logic [31:0] opb,
                                      input logic [7:0] count, input logic [11:0] flags);
        t_alu_op op;
        op.mode  = mode;
        op.wc    = wc;
        op.opa   = opa;
        op.opb   = opb;
        op.count = count;
        op.flags = flags;
        return op;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h8000_8080;
            3:       v = 32'h7FFF_7F7F;
            4:       v = 32'h1 << $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_alu_op rand_op();
        t_alu_op op;
        if ($urandom_range(0, 9) == 0) begin
            op.mode = 5'($urandom_range(MODE_RCR + 1, MODE_LAST));
        end else begin
            op.mode = 5'($urandom_range(MODE_ADD, MODE_RCR));
        end
        op.wc  = ($urandom_range(0, 7) == 0) ? WC_RSVD : 2'($urandom_range(WC_8, WC_32));
        op.opa = pick_operand();
        op.opb = pick_operand();
        case ($urandom_range(0, 3))
            0:       op.count = 8'($urandom_range(0, 255));
            1:       op.count = 8'($urandom_range(0, 2));
            default: op.count = 8'($urandom_range(0, 33));
        endcase
        op.flags = 12'($urandom);
        return op;
    endfunction

    task automatic send_op(input t_alu_op op);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= op.mode;
        i_width_code  <= op.wc;
        i_operand_a   <= op.opa;
        i_operand_b   <= op.opb;
        i_shift_count <= op.count;
        i_flags_in    <= op.flags;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(alu_predict(op));
        ops_sent++;
    endtask

    task automatic wait_empty();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!sink_idle_en) begin
            sink_burst = 0;
        end else if (sink_burst > 0) begin
            sink_burst--;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_burst = $urandom_range(1, 17);
        end
        i_stall <= long_hold || (sink_burst > 0);
    end

    initial begin
        forever begin
            @(hold_trig);
            long_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            long_hold = 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_alu_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: result %h", o_result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (o_result !== want.result) begin
                    $error("result: expected %h, got %h", want.result, o_result);
                    errors++;
                end
                if (o_flags_out !== want.flags) begin
                    $error("flags_out: expected %h, got %h", want.flags, o_flags_out);
                    errors++;
                end
                if (o_write_back !== want.wb) begin
                    $error("write_back: expected %b, got %b", want.wb, o_write_back);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_arith_flags();
        send_op(op_of(MODE_ADD, WC_8,  32'hFFFF_FFFF, 32'h0000_0001, 8'd0, 12'h000));
        send_op(op_of(MODE_ADC, WC_16, 32'h0000_7FFF, 32'h0000_0000, 8'd0, 12'h001));
        send_op(op_of(MODE_SUB, WC_32, 32'h0000_0000, 32'h0000_0001, 8'd0, 12'h000));
        send_op(op_of(MODE_SBB, WC_8,  32'h0000_0080, 32'h0000_007F, 8'd0, 12'h001));
        send_op(op_of(MODE_NEG, WC_8,  32'h0000_0080, 32'h0000_0000, 8'd0, 12'hFFF));
        send_op(op_of(MODE_CMP, WC_32, 32'h8000_0000, 32'h8000_0000, 8'd0, 12'hFFF));
        send_op(op_of(MODE_INC, WC_16, 32'hFFFF_7FFF, 32'h0000_0000, 8'd0, 12'h001));
        send_op(op_of(MODE_DEC, WC_8,  32'h0000_0000, 32'hFFFF_FFFF, 8'd0, 12'h000));
    endtask

    task automatic test_logic_flags();
        send_op(op_of(MODE_AND,  WC_32,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 12'hFFF));
        send_op(op_of(MODE_OR,   WC_RSVD, 32'h0000_0000, 32'h0000_0000, 8'd0, 12'h801));
        send_op(op_of(MODE_XOR,  WC_16,   32'h0000_A5A5, 32'h0000_5A5A, 8'd0, 12'h000));
        send_op(op_of(MODE_NOT,  WC_8,    32'h0000_0055, 32'h0000_0000, 8'd0, 12'hA5A));
        send_op(op_of(MODE_TEST, WC_8,    32'h0000_0003, 32'h0000_0001, 8'd0, 12'hFFF));
    endtask

    task automatic test_shift_rotate();
        send_op(op_of(MODE_SHL,  WC_8,  32'h0000_0081, 32'h0, 8'd1,   12'h000));
        send_op(op_of(MODE_SHR,  WC_16, 32'h0000_8001, 32'h0, 8'd1,   12'h000));
        send_op(op_of(MODE_SAR,  WC_32, 32'h8000_0000, 32'h0, 8'd31,  12'h000));
        send_op(op_of(MODE_SHL,  WC_8,  32'h0000_00FF, 32'h0, 8'd20,  12'hFFF));
        send_op(op_of(MODE_SHLD, WC_16, 32'h0000_4000, 32'hFFFF_FFFF, 8'd1, 12'h000));
        send_op(op_of(MODE_SHRD, WC_8,  32'h0000_00C3, 32'h0000_005A, 8'd12, 12'h000));
        send_op(op_of(MODE_ROL,  WC_8,  32'h0000_0081, 32'h0, 8'd8,   12'h801));
        send_op(op_of(MODE_ROR,  WC_32, 32'h0000_0001, 32'h0, 8'hFF,  12'h000));
        send_op(op_of(MODE_RCL,  WC_8,  32'h0000_0080, 32'h0, 8'd9,   12'h001));
        send_op(op_of(MODE_RCR,  WC_16, 32'h0000_1234, 32'h0, 8'h20,  12'hFFF));
        send_op(op_of(MODE_SHR,  WC_32, 32'hDEAD_BEEF, 32'h0, 8'd0,   12'h0D5));
        send_op(op_of(MODE_LAST, WC_32, 32'hCAFE_F00D, 32'h1, 8'd3,   12'h123));
    endtask

    task automatic test_random_mix(input int unsigned count);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (count) send_op(rand_op());
    endtask

    task automatic test_full_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        -> hold_trig;
        repeat (40) send_op(rand_op());
    endtask

    task automatic test_drain_pause();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (12) send_op(rand_op());
        wait_empty();
        repeat (12) send_op(rand_op());
    endtask

    task automatic test_random_no_idle();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (60) send_op(rand_op());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_arith_flags();
        test_logic_flags();
        test_shift_rotate();
        test_random_mix(280);
        test_full_backpressure();
        test_drain_pause();
        test_random_no_idle();
        wait_empty();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d operations across every mode code and width code,", ops_sent);
        $display("with random stalls, a long output hold and a full drain; %0d results checked.",
                 results_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
